/* rtl/core/bfa_pkg.sv */
// Shared constants and types for the bitmap first-fit allocator.
package bfa_pkg;

  // Default bitmap length in slots
  localparam int unsigned SLOT_COUNT_DEF = 64;

  // Largest address or size in KB that a mark may name
  localparam logic [7:0] LIMIT_KB = 8'd128;

  // Request kinds
  localparam logic [1:0] KIND_FIND  = 2'd0;
  localparam logic [1:0] KIND_MARK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BOUNDS    = 2'd2;

  // Control broadcast to every bitmap cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

/* rtl/core/bfa_if.sv */
// Request and response channel interfaces of the allocator.
interface bfa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] start_kb;
  logic [7:0] size_kb;

  modport source (output valid, output kind, output start_kb, output size_kb, input ready);
  modport sink   (input valid, input kind, input start_kb, input size_kb, output ready);
endinterface

interface bfa_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] found_kb;

  modport source (output valid, output status, output found_kb, input ready);
  modport sink   (input valid, input status, input found_kb, output ready);
endinterface

/* rtl/core/bfa_cell.sv */
// One bitmap cell: holds the occupancy bit of one slot position in the ring.
module bfa_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfa_pkg::cell_ctrl_t ctrl_i,
  input  logic                next_i,
  output logic                bit_o
);
  import bfa_pkg::*;

  logic bit_q;
  logic bit_d;

  // Clear wins; otherwise take the neighbor's bit while the ring rotates
  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.clear) begin
      bit_d = 1'b0;
    end else if (ctrl_i.shift) begin
      bit_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

/* rtl/core/bitmap_first_fit_allocator.sv */
// Top level of the bitmap first-fit allocator: cell ring and scan controller.
//
// Usage: requests arrive on req_i (valid/ready), one word per request carrying
// kind, start_kb and size_kb; each request yields exactly one response word on
// rsp_o with status and found_kb.
// The bitmap lives in a ring of SLOT_COUNT one-bit cells. A find or an
// in-bounds mark rotates the ring once around, one slot per cycle, so the
// controller sees every slot in order at the head cell and writes the marked
// bit back into the tail cell.
// A find and an in-bounds mark pass through S_SCAN and then S_WAIT before the
// result enters the output register; a clear, an out-of-bounds mark and the
// unused kind go straight to S_WAIT. One request at a time: req_i.ready is
// high only when the block is idle, so no new request is taken before the
// last one's result has left the controller for the output register.
// A finished response sits in an output register; a new request is accepted
// while it waits. If the receiver stalls, the next result holds in the
// controller until the output register frees, and no request is taken then.
// Reset: the bitmap clears to all free, no response is pending, block is idle.
module bitmap_first_fit_allocator #(
  parameter int unsigned SLOT_COUNT = bfa_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfa_req_if.sink    req_i,
  bfa_rsp_if.source  rsp_o
);
  import bfa_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CW    = (IDX_W > 7) ? IDX_W + 1 : 9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_e;

  state_e           state_q, state_d;
  logic             mark_q, mark_d;
  logic [6:0]       first_q, first_d;
  logic [6:0]       len_q, len_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [6:0]       run_q, run_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] start_q, start_d;
  logic [1:0]       res_status_q, res_status_d;
  logic [6:0]       res_found_q, res_found_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [6:0]       out_found_q, out_found_d;

  cell_ctrl_t       ctrl;
  logic [SLOT_COUNT-1:0] cell_bits;
  logic             head;
  logic             feedback;
  logic             in_range;
  logic             run_done;
  logic [7:0]       mark_end;
  logic [6:0]       size_slots;

  // Ring of cells: each takes from its upper neighbor, the tail from feedback
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    logic next_bit;
    if (g == SLOT_COUNT - 1) begin : g_tail
      assign next_bit = feedback;
    end else begin : g_body
      assign next_bit = cell_bits[g+1];
    end
    bfa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .next_i (next_bit),
      .bit_o  (cell_bits[g])
    );
  end

  // Slot under the head cell and what goes back into the tail
  assign head     = cell_bits[0];
  assign in_range = (CW'(idx_q) >= CW'(first_q)) &&
                    (CW'(idx_q) < (CW'(first_q) + CW'(len_q)));
  assign feedback = head | (mark_q & in_range);
  assign run_done = (8'(run_q) + 8'd1) >= 8'(len_q);

  assign size_slots = req_i.size_kb[7:1];
  assign mark_end   = 8'(req_i.start_kb[7:1]) + 8'(size_slots);

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.found_kb = out_found_q;

  // Controller next state
  always_comb begin
    state_d      = state_q;
    mark_d       = mark_q;
    first_d      = first_q;
    len_d        = len_q;
    idx_d        = idx_q;
    run_d        = run_q;
    hit_d        = hit_q;
    start_d      = start_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    ctrl.shift   = 1'b0;
    ctrl.clear   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          idx_d        = '0;
          run_d        = '0;
          hit_d        = 1'b0;
          res_status_d = ST_OK;
          res_found_d  = '0;
          case (req_i.kind)
            KIND_FIND: begin
              // A zero-slot find still needs one free slot
              mark_d  = 1'b0;
              len_d   = (size_slots == 7'd0) ? 7'd1 : size_slots;
              first_d = '0;
              state_d = S_SCAN;
            end
            KIND_MARK: begin
              if (req_i.start_kb > LIMIT_KB || req_i.size_kb > LIMIT_KB ||
                  32'(mark_end) > SLOT_COUNT) begin
                res_status_d = ST_BOUNDS;
                state_d      = S_WAIT;
              end else begin
                mark_d  = 1'b1;
                first_d = req_i.start_kb[7:1];
                len_d   = size_slots;
                state_d = S_SCAN;
              end
            end
            KIND_CLEAR: begin
              ctrl.clear = 1'b1;
              state_d    = S_WAIT;
            end
            default: begin
              state_d = S_WAIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Rotate one slot; track the free run ending at the head slot
        ctrl.shift = 1'b1;
        idx_d      = idx_q + IDX_W'(1);
        if (head) begin
          run_d = '0;
        end else if (run_q != len_q) begin
          run_d = run_q + 7'd1;
        end
        if (!mark_q && !hit_q && !head && run_done) begin
          hit_d   = 1'b1;
          start_d = IDX_W'(CW'(idx_q) - CW'(len_q) + CW'(1));
        end
        if (idx_q == IDX_W'(SLOT_COUNT - 1)) begin
          state_d = S_WAIT;
          if (mark_q) begin
            res_status_d = ST_OK;
            res_found_d  = '0;
          end else if (hit_d) begin
            res_status_d = ST_OK;
            res_found_d  = 7'({start_d, 1'b0});
          end else begin
            res_status_d = ST_NOT_FOUND;
            res_found_d  = '0;
          end
        end
      end
      S_WAIT: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mark_q       <= 1'b0;
      idx_q        <= '0;
      run_q        <= '0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mark_q       <= mark_d;
      idx_q        <= idx_d;
      run_q        <= run_d;
      hit_q        <= hit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    first_q      <= first_d;
    len_q        <= len_d;
    start_q      <= start_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
  end

endmodule

/* tb/tb_bitmap_first_fit_allocator.sv */
// Testbench for the bitmap first-fit allocator: queue-fed driver, monitor, bitmap predictor.
`timescale 1ns / 1ps

module tb_bitmap_first_fit_allocator;
  import bfa_pkg::*;

  localparam int unsigned SLOTS       = SLOT_COUNT_DEF;
  localparam int          RAND_ITEMS  = 2000;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          MAX_SHOWN   = 10;
  // Kind code that the block must treat as a no-op
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] start_kb;
    logic [7:0] size_kb;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] found_kb;
  } alloc_rsp_t;

  logic clk_i;
  logic rst_ni;

  bfa_req_if req_bus ();
  bfa_rsp_if rsp_bus ();

  bitmap_first_fit_allocator #(
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  alloc_req_t       pending_reqs[$];
  alloc_rsp_t       expected_rsps[$];
  logic [SLOTS-1:0] occ_map;

  int total_items;
  int offer_cnt;
  int accept_cnt;
  int rsp_cnt;
  int err_cnt;
  int cycle_cnt;
  int found_cnt;
  int miss_cnt;
  int mark_ok_cnt;
  int bounds_cnt;
  int clear_cnt;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Apply one request to the shadow bitmap and return the expected response
  function automatic alloc_rsp_t predict_alloc(input alloc_req_t r);
    alloc_rsp_t res;
    int         len;
    int         first;
    logic       run_ok;
    res.status   = ST_OK;
    res.found_kb = '0;
    case (r.kind)
      KIND_FIND: begin
        len        = int'(r.size_kb) / 2;
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < int'(SLOTS); i++) begin
          // Slots past the end count as busy
          run_ok = !occ_map[i];
          for (int j = 0; j < len && run_ok; j++) begin
            if (i + j >= int'(SLOTS) || occ_map[i + j]) run_ok = 1'b0;
          end
          if (run_ok) begin
            res.status   = ST_OK;
            res.found_kb = 7'(i * 2);
            break;
          end
        end
      end
      KIND_MARK: begin
        first = int'(r.start_kb) / 2;
        len   = int'(r.size_kb) / 2;
        if (r.start_kb > LIMIT_KB || r.size_kb > LIMIT_KB || first + len > int'(SLOTS)) begin
          res.status = ST_BOUNDS;
        end else begin
          for (int i = first; i < first + len; i++) occ_map[i] = 1'b1;
        end
      end
      KIND_CLEAR: begin
        occ_map = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic add_req(input logic [1:0] kind, input int start_kb, input int size_kb);
    alloc_req_t r;
    r.kind     = kind;
    r.start_kb = 8'(start_kb);
    r.size_kb  = 8'(size_kb);
    pending_reqs.push_back(r);
  endtask

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Driver: present the next request word when the previous one was taken
  always @(negedge clk_i) begin
    int idle_pct;
    alloc_req_t r;
    idle_pct = (offer_cnt * 3 < total_items) ? 6 :
               (offer_cnt * 3 < total_items * 2) ? 62 : 0;
    if (rst_ni && accept_cnt == offer_cnt) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        r = pending_reqs.pop_front();
        req_bus.kind     <= r.kind;
        req_bus.start_kb <= r.start_kb;
        req_bus.size_kb  <= r.size_kb;
        req_bus.valid    <= 1'b1;
        offer_cnt++;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall the response channel at random
  always @(negedge clk_i) begin
    int idle_pct;
    idle_pct = (offer_cnt * 3 < total_items) ? 62 :
               (offer_cnt * 3 < total_items * 2) ? 6 : 0;
    rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Request monitor: predict each accepted word
  always @(posedge clk_i) begin
    alloc_req_t r;
    alloc_rsp_t e;
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      r.kind     = req_bus.kind;
      r.start_kb = req_bus.start_kb;
      r.size_kb  = req_bus.size_kb;
      e          = predict_alloc(r);
      expected_rsps.push_back(e);
      accept_cnt++;
      if (r.kind == KIND_FIND && e.status == ST_OK) found_cnt++;
      if (e.status == ST_NOT_FOUND) miss_cnt++;
      if (r.kind == KIND_MARK && e.status == ST_OK) mark_ok_cnt++;
      if (e.status == ST_BOUNDS) bounds_cnt++;
      if (r.kind == KIND_CLEAR) clear_cnt++;
    end
  end

  // Response monitor: compare against the oldest expectation
  always @(posedge clk_i) begin
    alloc_rsp_t e;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      rsp_cnt++;
      if (expected_rsps.size() == 0) begin
        flag_mismatch($sformatf("unexpected response status=%0d found_kb=%0d",
                                rsp_bus.status, rsp_bus.found_kb));
      end else begin
        e = expected_rsps.pop_front();
        if (rsp_bus.status !== e.status)
          flag_mismatch($sformatf("response %0d status exp=%0d got=%0d",
                                  rsp_cnt, e.status, rsp_bus.status));
        if (rsp_bus.found_kb !== e.found_kb)
          flag_mismatch($sformatf("response %0d found_kb exp=%0d got=%0d",
                                  rsp_cnt, e.found_kb, rsp_bus.found_kb));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_cnt, expected_rsps.size());
      $display("tb_bitmap_first_fit_allocator: errors");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int sel;
    int len;
    int first;
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.kind     = KIND_FIND;
    req_bus.start_kb = '0;
    req_bus.size_kb  = '0;
    rsp_bus.ready    = 1'b0;
    occ_map          = '0;

    // Directed: empty map, size extremes, mark bounds, full map, runs at the end
    add_req(KIND_FIND,   0,   0);
    add_req(KIND_FIND,   0,   1);
    add_req(KIND_FIND,   0, 128);
    add_req(KIND_FIND, 255, 130);
    add_req(KIND_FIND,   0, 255);
    add_req(KIND_MARK,   0,   0);
    add_req(KIND_MARK, 129,   2);
    add_req(KIND_MARK,   0, 129);
    add_req(KIND_MARK, 255, 255);
    add_req(KIND_MARK, 128,   2);
    add_req(KIND_MARK, 127,   3);
    add_req(KIND_FIND,   0, 128);
    add_req(KIND_FIND,   0, 126);
    add_req(KIND_MARK,   0, 128);
    add_req(KIND_FIND,   0,   0);
    add_req(KIND_FIND,   0,   2);
    add_req(KIND_UNUSED, 255, 255);
    add_req(KIND_CLEAR, 255, 255);
    add_req(KIND_MARK,   1,   3);
    add_req(KIND_MARK,   4,   4);
    add_req(KIND_FIND,   0,   4);
    add_req(KIND_FIND,   0,   1);
    add_req(KIND_MARK,   2, 124);
    add_req(KIND_FIND,   0,   2);
    add_req(KIND_FIND,   0,   4);

    // Random: mostly finds and in-bounds marks, with clears, no-ops and bad marks
    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel = $urandom_range(99);
      if (sel < 42) begin
        add_req(KIND_FIND, $urandom_range(255),
                ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(40));
      end else if (sel < 80) begin
        len   = ($urandom_range(4) == 0) ? $urandom_range(SLOTS) : $urandom_range(12);
        first = $urandom_range(SLOTS - len);
        add_req(KIND_MARK, first * 2 + $urandom_range(1), len * 2 + $urandom_range(1));
      end else if (sel < 86) begin
        add_req(KIND_CLEAR, $urandom_range(255), $urandom_range(255));
      end else if (sel < 90) begin
        add_req(KIND_UNUSED, $urandom_range(255), $urandom_range(255));
      end else begin
        add_req(KIND_MARK, $urandom_range(255), $urandom_range(255));
      end
    end
    total_items = pending_reqs.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all words taken, all responses back, then a quiet window
    while (pending_reqs.size() != 0 || accept_cnt != offer_cnt) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
    if (expected_rsps.size() != 0)
      flag_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));

    $display("run: %0d requests, %0d responses, %0d finds hit, %0d not found",
             accept_cnt, rsp_cnt, found_cnt, miss_cnt);
    $display("run: %0d marks applied, %0d out of bounds, %0d clears, %0d mismatches",
             mark_ok_cnt, bounds_cnt, clear_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_bitmap_first_fit_allocator: clean");
    end else begin
      $display("tb_bitmap_first_fit_allocator: errors");
    end
    $finish;
  end

endmodule
